>>> design/first_fit_block_allocator_assert.svh
// Assertion macros for the allocator checker.
`ifndef FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define FIRST_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FFBA_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define FFBA_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

// Next-cycle implication that also holds across reset.
`define FFBA_ASSERT_NEXT_ALWAYS(label, ante, cons, msg) \
   label: assert property (@(posedge clock) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/ffba_pkg.sv
// Types and constants shared by the first-fit block allocator.
`timescale 1ns / 1ps
`default_nettype none
package ffba_pkg;

   localparam int MAX_BLOCKS   = 64;
   localparam int HEADER_BYTES = 16;
   localparam int ADDR_BITS    = 20;
   localparam int SIZE_BITS    = 20;
   localparam int LIMIT_BITS   = 21;
   localparam int IDX_BITS     = $clog2(MAX_BLOCKS);
   localparam int CNT_BITS     = IDX_BITS + 1;
   // wide enough for top + header + size and for the data address range check
   localparam int SUM_BITS     = ((LIMIT_BITS > ADDR_BITS) ? LIMIT_BITS : ADDR_BITS) + 2;

   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = LIMIT_BITS'(1048576);

   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } opcode_type;

   typedef enum logic [2:0] {
      ST_REUSED  = 3'd0,
      ST_NEW     = 3'd1,
      ST_ZERO    = 3'd2,
      ST_OOM     = 3'd3,
      ST_NULL    = 3'd4,
      ST_INVALID = 3'd5,
      ST_ALREADY = 3'd6
   } status_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] address;
      logic [SIZE_BITS-1:0] size;
      logic                 is_free;
   } entry_type;

   localparam int ENTRY_BITS = $bits(entry_type);

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_COMMIT
   } state_type;

   typedef struct packed {
      logic start;
      logic scan;
      logic commit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic scan_hit;
      logic scan_miss;
      logic slot_free;
   } dp_status_type;

endpackage
`default_nettype wire

>>> design/ffba_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module ffba_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

>>> design/ffba_ctrl.sv
// Sequencer for the allocator: accept, table scan, commit.
`timescale 1ns / 1ps
`default_nettype none
module ffba_ctrl (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_valid,
   output logic                         req_ready,
   input  wire ffba_pkg::dp_status_type status,
   output ffba_pkg::ctrl_cmd_type       cmd
);

   ffba_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffba_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ffba_pkg::S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ffba_pkg::S_SCAN;
            end
         end
         ffba_pkg::S_SCAN: begin
            cmd.scan = 1'b1;
            if (status.scan_hit || status.scan_miss) begin
               state_in = ffba_pkg::S_COMMIT;
            end
         end
         ffba_pkg::S_COMMIT: begin
            // hold until the result register can take the new response
            if (status.slot_free) begin
               cmd.commit = 1'b1;
               state_in   = ffba_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ffba_pkg::S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

>>> design/ffba_datapath.sv
// Allocator datapath: block table, heap pointer, scan compare and result register.
`timescale 1ns / 1ps
`default_nettype none
module ffba_datapath (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire ffba_pkg::ctrl_cmd_type                cmd,
   output ffba_pkg::dp_status_type                    status,
   input  wire logic                                  req_opcode,
   input  wire logic [ffba_pkg::SIZE_BITS-1:0]        req_request_size,
   input  wire logic [ffba_pkg::ADDR_BITS-1:0]        req_block_address,
   input  wire logic                                  csr_wr_en,
   input  wire logic [ffba_pkg::LIMIT_BITS-1:0]       csr_wr_data,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic      [2:0]                            rsp_status,
   output logic      [ffba_pkg::ADDR_BITS-1:0]        rsp_data_address
);

   localparam int IB = ffba_pkg::IDX_BITS;
   localparam int CB = ffba_pkg::CNT_BITS;
   localparam int SB = ffba_pkg::SUM_BITS;

   // control state
   logic [ffba_pkg::LIMIT_BITS-1:0] limit_ff, limit_in;
   logic [ffba_pkg::LIMIT_BITS-1:0] heap_top_ff, heap_top_in;
   logic [CB-1:0]                   count_ff, count_in;
   logic [CB-1:0]                   scan_idx_ff, scan_idx_in;
   logic                            cmp_valid_ff, cmp_valid_in;
   logic                            rsp_valid_ff, rsp_valid_in;

   // payload
   ffba_pkg::opcode_type            op_ff, op_in;
   logic [ffba_pkg::SIZE_BITS-1:0]  size_ff, size_in;
   logic [ffba_pkg::ADDR_BITS-1:0]  baddr_ff, baddr_in;
   logic [SB-1:0]                   data_ff, data_in;
   logic                            early_ff, early_in;
   logic                            found_ff, found_in;
   logic [IB-1:0]                   cmp_idx_ff, cmp_idx_in;
   logic [IB-1:0]                   hit_idx_ff, hit_idx_in;
   ffba_pkg::entry_type             hit_entry_ff, hit_entry_in;
   ffba_pkg::status_type            rsp_status_ff, rsp_status_in;
   logic [ffba_pkg::ADDR_BITS-1:0]  rsp_addr_ff, rsp_addr_in;

   logic                            rd_en;
   logic [IB-1:0]                   rd_addr;
   logic [ffba_pkg::ENTRY_BITS-1:0] rd_bits;
   ffba_pkg::entry_type             rd_entry;
   logic                            match;

   logic                            wr_en;
   logic [IB-1:0]                   wr_addr;
   ffba_pkg::entry_type             wr_entry;

   logic [SB-1:0]                   end_sum;
   logic                            oom;
   ffba_pkg::status_type            res_status;
   logic [ffba_pkg::ADDR_BITS-1:0]  res_addr;
   logic                            res_write;
   logic                            res_append;

   ffba_ram #(
      .WIDTH(ffba_pkg::ENTRY_BITS),
      .DEPTH(ffba_pkg::MAX_BLOCKS)
   ) u_table (
      .clock  (clock),
      .wr_en  (wr_en),
      .wr_addr(wr_addr),
      .wr_data(wr_entry),
      .rd_en  (rd_en),
      .rd_addr(rd_addr),
      .rd_data(rd_bits)
   );

   assign rd_entry = ffba_pkg::entry_type'(rd_bits);

   // scan: one table read per cycle, each entry compared in the cycle after its read
   always_comb begin
      rd_en   = cmd.scan && (scan_idx_ff < count_ff);
      rd_addr = scan_idx_ff[IB-1:0];
      if (op_ff == ffba_pkg::OP_ALLOC) begin
         match = rd_entry.is_free && (rd_entry.size >= size_ff);
      end else begin
         match = (rd_entry.address == baddr_ff);
      end
      status.scan_hit  = cmp_valid_ff && match && !early_ff;
      status.scan_miss = early_ff || (!cmp_valid_ff && (scan_idx_ff >= count_ff));
      status.slot_free = !rsp_valid_ff || rsp_ready;
   end

   // outcome of the request, applied on commit
   always_comb begin
      end_sum    = data_ff + SB'(size_ff);
      oom        = (count_ff >= CB'(ffba_pkg::MAX_BLOCKS))
                   || (end_sum > SB'(limit_ff))
                   || (data_ff[SB-1:ffba_pkg::ADDR_BITS] != '0);
      res_status = ffba_pkg::ST_INVALID;
      res_addr   = '0;
      res_write  = 1'b0;
      res_append = 1'b0;
      wr_addr    = hit_idx_ff;
      wr_entry   = hit_entry_ff;
      if (op_ff == ffba_pkg::OP_ALLOC) begin
         if (early_ff) begin
            res_status = ffba_pkg::ST_ZERO;
         end else if (found_ff) begin
            res_status       = ffba_pkg::ST_REUSED;
            res_addr         = hit_entry_ff.address;
            res_write        = 1'b1;
            wr_entry.is_free = 1'b0;
         end else if (oom) begin
            res_status = ffba_pkg::ST_OOM;
         end else begin
            res_status       = ffba_pkg::ST_NEW;
            res_addr         = data_ff[ffba_pkg::ADDR_BITS-1:0];
            res_write        = 1'b1;
            res_append       = 1'b1;
            wr_addr          = count_ff[IB-1:0];
            wr_entry.address = data_ff[ffba_pkg::ADDR_BITS-1:0];
            wr_entry.size    = size_ff;
            wr_entry.is_free = 1'b0;
         end
      end else begin
         if (early_ff) begin
            res_status = ffba_pkg::ST_NULL;
         end else if (found_ff) begin
            if (hit_entry_ff.is_free) begin
               res_status = ffba_pkg::ST_ALREADY;
            end else begin
               res_status       = ffba_pkg::ST_REUSED;
               res_write        = 1'b1;
               wr_entry.is_free = 1'b1;
            end
         end
      end
      wr_en = cmd.commit && res_write;
   end

   always_comb begin
      limit_in      = csr_wr_en ? csr_wr_data : limit_ff;
      heap_top_in   = heap_top_ff;
      count_in      = count_ff;
      scan_idx_in   = scan_idx_ff;
      cmp_valid_in  = rd_en;
      cmp_idx_in    = rd_addr;
      rsp_valid_in  = rsp_ready ? 1'b0 : rsp_valid_ff;
      op_in         = op_ff;
      size_in       = size_ff;
      baddr_in      = baddr_ff;
      data_in       = data_ff;
      early_in      = early_ff;
      found_in      = found_ff;
      hit_idx_in    = hit_idx_ff;
      hit_entry_in  = hit_entry_ff;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;

      if (rd_en) begin
         scan_idx_in = scan_idx_ff + CB'(1);
      end
      if (cmd.start) begin
         op_in        = ffba_pkg::opcode_type'(req_opcode);
         size_in      = req_request_size;
         baddr_in     = req_block_address;
         data_in      = SB'(heap_top_ff) + SB'(ffba_pkg::HEADER_BYTES);
         early_in     = (req_opcode == ffba_pkg::OP_ALLOC) ? (req_request_size == '0)
                                                           : (req_block_address == '0);
         scan_idx_in  = '0;
         cmp_valid_in = 1'b0;
      end
      if (cmd.scan && (status.scan_hit || status.scan_miss)) begin
         found_in     = status.scan_hit;
         hit_idx_in   = cmp_idx_ff;
         hit_entry_in = rd_entry;
      end
      if (cmd.commit) begin
         rsp_valid_in  = 1'b1;
         rsp_status_in = res_status;
         rsp_addr_in   = res_addr;
         if (res_append) begin
            count_in    = count_ff + CB'(1);
            heap_top_in = end_sum[ffba_pkg::LIMIT_BITS-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff     <= ffba_pkg::LIMIT_RESET;
         heap_top_ff  <= '0;
         count_ff     <= '0;
         scan_idx_ff  <= '0;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         limit_ff     <= limit_in;
         heap_top_ff  <= heap_top_in;
         count_ff     <= count_in;
         scan_idx_ff  <= scan_idx_in;
         cmp_valid_ff <= cmp_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      size_ff       <= size_in;
      baddr_ff      <= baddr_in;
      data_ff       <= data_in;
      early_ff      <= early_in;
      found_ff      <= found_in;
      cmp_idx_ff    <= cmp_idx_in;
      hit_idx_ff    <= hit_idx_in;
      hit_entry_ff  <= hit_entry_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_data_address = rsp_addr_ff;

endmodule
`default_nettype wire

>>> design/first_fit_block_allocator.sv
// First-fit block allocator top level: sequencer plus datapath.
// A zero size or null request, or an empty table, ends the scan at once; else a miss reads
// every table entry and a hit stops at the first match, with at most MAX_BLOCKS entries read.
// Throughput: one request in flight; the next is accepted the cycle after commit.
// Reset (synchronous, active high) clears count, heap top and handshake state and loads
// LIMIT_RESET into the limit; the table is not cleared, since reads stop at the count.
`timescale 1ns / 1ps
`default_nettype none
module first_fit_block_allocator (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic                            req_opcode,
   input  wire logic [ffba_pkg::SIZE_BITS-1:0]  req_request_size,
   input  wire logic [ffba_pkg::ADDR_BITS-1:0]  req_block_address,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [2:0]                      rsp_status,
   output logic      [ffba_pkg::ADDR_BITS-1:0]  rsp_data_address,
   input  wire logic                            csr_wr_en,
   input  wire logic [ffba_pkg::LIMIT_BITS-1:0] csr_wr_data
);

   ffba_pkg::ctrl_cmd_type  cmd;
   ffba_pkg::dp_status_type status;

   ffba_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   ffba_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_opcode       (req_opcode),
      .req_request_size (req_request_size),
      .req_block_address(req_block_address),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_status       (rsp_status),
      .rsp_data_address (rsp_data_address)
   );

endmodule
`default_nettype wire

>>> design/ffba_checker.sv
// Port-level checks for the allocator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "first_fit_block_allocator_assert.svh"
module ffba_checker (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            req_valid,
   input wire logic                            req_ready,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_ready,
   input wire logic [2:0]                      rsp_status,
   input wire logic [ffba_pkg::ADDR_BITS-1:0]  rsp_data_address
);

   logic req_fire;
   logic rsp_failed;

   assign req_fire   = req_valid && req_ready;
   // failures and frees never carry an address
   assign rsp_failed = (rsp_status != ffba_pkg::ST_NEW) && (rsp_status != ffba_pkg::ST_REUSED);

   `FFBA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status) && $stable(rsp_data_address), "response changed while stalled")
   `FFBA_ASSERT_NEXT(a_one_in_flight, req_fire, !req_ready, "second request taken during a scan")
   `FFBA_ASSERT_NOW(a_fail_addr_zero, rsp_valid && rsp_failed, rsp_data_address == '0, "failed request returned an address")
   `FFBA_ASSERT_NOW(a_new_addr_nonzero, rsp_valid && (rsp_status == ffba_pkg::ST_NEW), rsp_data_address != '0, "new block at null address")
   `FFBA_ASSERT_NEXT_ALWAYS(a_reset_idle, reset, !rsp_valid, "response pending after reset")

endmodule

bind first_fit_block_allocator ffba_checker u_checker (.*);
`default_nettype wire
